FILE: hdl/ast_pkg.sv
`default_nettype none
package ast_pkg;

  localparam logic [3:0] KIND_TEXT      = 4'd0;
  localparam logic [3:0] KIND_COMMA     = 4'd1;
  localparam logic [3:0] KIND_NEWLINE   = 4'd2;
  localparam logic [3:0] KIND_DIRECTIVE = 4'd3;
  localparam logic [3:0] KIND_LABEL     = 4'd4;
  localparam logic [3:0] KIND_SYMBOL    = 4'd5;
  localparam logic [3:0] KIND_NUMBER    = 4'd6;
  localparam logic [3:0] KIND_STRING    = 4'd7;
  localparam logic [3:0] KIND_REGISTER  = 4'd8;
  localparam logic [3:0] KIND_ERROR     = 4'd9;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_BAD_CHAR = 3'd1;
  localparam logic [2:0] ERR_BAD_REG  = 3'd2;
  localparam logic [2:0] ERR_UNTERM   = 3'd3;
  localparam logic [2:0] ERR_RANGE    = 3'd4;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam int MAX_RESULTS = 4;

  typedef struct packed {
    logic [3:0]  kind;
    logic [7:0]  text;
    logic [31:0] value;
    logic [2:0]  err;
    logic [15:0] line;
    logic [15:0] col;
  } res_t;

  // ABI register names, packed first character highest.
  localparam logic [31:0] NAME_PACK [32] = '{
    32'h7a65726f, 32'h00006174, 32'h00007630, 32'h00007631,
    32'h00006130, 32'h00006131, 32'h00006132, 32'h00006133,
    32'h00007430, 32'h00007431, 32'h00007432, 32'h00007433,
    32'h00007434, 32'h00007435, 32'h00007436, 32'h00007437,
    32'h00007330, 32'h00007331, 32'h00007332, 32'h00007333,
    32'h00007334, 32'h00007335, 32'h00007336, 32'h00007337,
    32'h00007438, 32'h00007439, 32'h00006b30, 32'h00006b31,
    32'h00006770, 32'h00007370, 32'h00006670, 32'h00007261
  };

  // Returns {hit, index}.
  function automatic logic [5:0] reg_lookup(input logic [31:0] packed_name,
                                            input logic [2:0] len);
    logic [5:0] r;
    logic [2:0] nlen;
    r = 6'd0;
    for (int i = 0; i < 32; i++) begin
      nlen = (i == 0) ? 3'd4 : 3'd2;
      if (!r[5] && len == nlen && packed_name == NAME_PACK[i]) begin
        r = {1'b1, 5'(i)};
      end
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  // Digit value in the given base, or 16 when the character is no digit of it.
  function automatic logic [4:0] digit_in(input logic [7:0] c, input logic [1:0] base);
    logic [4:0] v;
    v = 5'd16;
    if (is_digit(c)) v = 5'(c - 8'h30);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    if (base == BASE_DEC && v > 5'd9) v = 5'd16;
    if (base == BASE_OCT && v > 5'd7) v = 5'd16;
    return v;
  endfunction

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'h62:   r = 8'd8;
      8'h66:   r = 8'd12;
      8'h6e:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h76:   r = 8'd11;
      default: r = c;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/ast_if.sv
`default_nettype none
interface ast_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       last_char;
  modport source (output valid, output char_byte, output last_char, input ready);
  modport sink (input valid, input char_byte, input last_char, output ready);
endinterface

interface ast_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         token_kind;
  logic [7:0]         text_byte;
  logic signed [31:0] token_value;
  logic [2:0]         error_code;
  logic [15:0]        start_line;
  logic [15:0]        start_column;
  logic               last_result;
  modport source (output valid, output token_kind, output text_byte, output token_value,
                  output error_code, output start_line, output start_column,
                  output last_result, input ready);
  modport sink (input valid, input token_kind, input text_byte, input token_value,
                input error_code, input start_line, input start_column,
                input last_result, output ready);
endinterface
`default_nettype wire

FILE: hdl/ast_step.sv
`default_nettype none
module ast_step
  import ast_pkg::*;
#(
  parameter int LINE_BITS      = 16,
  parameter int COLUMN_BITS    = 16,
  parameter int REG_NAME_CHARS = 4
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic [7:0]     char_byte,
  input  wire logic           last_char,
  output res_t [3:0]          res_q,
  output logic [2:0]          res_n
);

  localparam int LB = LINE_BITS;
  localparam int CB = COLUMN_BITS;
  localparam int RB = 8 * REG_NAME_CHARS;
  localparam int LENW = $clog2(REG_NAME_CHARS + 2);

  localparam logic [3:0] M_IDLE = 4'd0, M_COMMENT = 4'd1, M_DIRECTIVE = 4'd2,
                         M_SYMBOL = 4'd3, M_REGISTER = 4'd4, M_NSIGN = 4'd5,
                         M_NZERO = 4'd6, M_NXPEND = 4'd7, M_NDIGITS = 4'd8,
                         M_STRING = 4'd9, M_ESCAPE = 4'd10, M_OCTAL = 4'd11,
                         M_HALT = 4'd12;

  localparam logic [32:0] MAG_SAT = 33'h100000000;

  logic [3:0]      mode_r, mode_nxt;
  logic [LB-1:0]   cl_r, cl_nxt, tl_r, tl_nxt;
  logic [CB-1:0]   cc_r, cc_nxt, tc_r, tc_nxt, xcol_r, xcol_nxt;
  logic [32:0]     mag_r, mag_nxt;
  logic            neg_r, neg_nxt;
  logic [1:0]      base_r, base_nxt;
  logic [RB-1:0]   rbuf_r, rbuf_nxt;
  logic [LENW-1:0] rlen_r, rlen_nxt;
  logic            rdig_r, rdig_nxt;
  logic [8:0]      esc_r, esc_nxt;
  logic [1:0]      escd_r, escd_nxt;

  function automatic res_t mk(input logic [3:0] k, input logic [7:0] b,
                              input logic [31:0] v, input logic [2:0] e,
                              input logic [LB-1:0] l, input logic [CB-1:0] c);
    res_t r;
    r.kind  = k;
    r.text  = b;
    r.value = v;
    r.err   = e;
    r.line  = 16'(l);
    r.col   = 16'(c);
    return r;
  endfunction

  function automatic void push(inout res_t [3:0] q, inout logic [2:0] n, input res_t r);
    if (n < 3'(MAX_RESULTS)) begin
      q[n[1:0]] = r;
      n = n + 3'd1;
    end
  endfunction

  always_comb begin
    res_t [3:0]  q;
    logic [2:0]  n;
    logic        go;
    logic [4:0]  v;
    logic [7:0]  c;
    logic [37:0] prod;
    logic [5:0]  hit;
    logic [31:0] val;
    logic        bad;

    q = '0;
    n = 3'd0;
    c = char_byte;
    mode_nxt = mode_r; cl_nxt = cl_r; cc_nxt = cc_r; tl_nxt = tl_r; tc_nxt = tc_r;
    xcol_nxt = xcol_r; mag_nxt = mag_r; neg_nxt = neg_r; base_nxt = base_r;
    rbuf_nxt = rbuf_r; rlen_nxt = rlen_r; rdig_nxt = rdig_r;
    esc_nxt = esc_r; escd_nxt = escd_r;
    go = (mode_r != M_HALT);
    v = 5'd0; prod = '0; hit = '0; val = '0; bad = 1'b0;

    for (int p = 0; p < 3; p++) begin
      if (go) begin
        go = 1'b0;
        unique case (mode_nxt)
          M_IDLE: begin
            if (!is_blank(c)) begin
              tl_nxt = cl_r;
              tc_nxt = cc_r;
              if (c == 8'h2e) mode_nxt = M_DIRECTIVE;
              else if (c == 8'h24) begin
                mode_nxt = M_REGISTER;
                rbuf_nxt = '0; rlen_nxt = '0; rdig_nxt = 1'b1; mag_nxt = '0;
              end else if (is_alpha(c)) begin
                mode_nxt = M_SYMBOL;
                push(q, n, mk(KIND_TEXT, c, '0, ERR_NONE, cl_r, cc_r));
              end else if (is_digit(c) || c == 8'h2d || c == 8'h2b) begin
                mag_nxt = '0; neg_nxt = 1'b0; base_nxt = BASE_DEC;
                if (c == 8'h2d || c == 8'h2b) begin
                  neg_nxt = (c == 8'h2d);
                  mode_nxt = M_NSIGN;
                end else if (c == 8'h30) mode_nxt = M_NZERO;
                else begin
                  mag_nxt = 33'(c - 8'h30);
                  mode_nxt = M_NDIGITS;
                end
              end else if (c == 8'h22) mode_nxt = M_STRING;
              else if (c == 8'h2c) push(q, n, mk(KIND_COMMA, '0, '0, ERR_NONE, cl_r, cc_r));
              else if (c == 8'h0a) push(q, n, mk(KIND_NEWLINE, '0, '0, ERR_NONE, cl_r, cc_r));
              else if (c == 8'h3b) mode_nxt = M_COMMENT;
              else begin
                push(q, n, mk(KIND_ERROR, '0, '0, ERR_BAD_CHAR, cl_r, cc_r));
                mode_nxt = M_HALT;
              end
            end
          end
          M_COMMENT: begin
            if (c == 8'h0a) begin
              mode_nxt = M_IDLE;
              go = 1'b1;
            end
          end
          M_DIRECTIVE: begin
            if (is_alpha(c)) push(q, n, mk(KIND_TEXT, c, '0, ERR_NONE, tl_nxt, tc_nxt));
            else begin
              push(q, n, mk(KIND_DIRECTIVE, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_IDLE;
              go = 1'b1;
            end
          end
          M_SYMBOL: begin
            if (is_alpha(c)) push(q, n, mk(KIND_TEXT, c, '0, ERR_NONE, tl_nxt, tc_nxt));
            else if (c == 8'h3a) begin
              push(q, n, mk(KIND_LABEL, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_IDLE;
            end else begin
              push(q, n, mk(KIND_SYMBOL, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_IDLE;
              go = 1'b1;
            end
          end
          M_REGISTER: begin
            if (is_alpha(c) || is_digit(c)) begin
              if (!is_digit(c)) rdig_nxt = 1'b0;
              if (rdig_nxt) begin
                mag_nxt = (mag_nxt << 3) + (mag_nxt << 1) + 33'(c - 8'h30);
                if (mag_nxt > 33'd32) mag_nxt = 33'd32;
              end
              if (rlen_nxt < LENW'(REG_NAME_CHARS)) rbuf_nxt = {rbuf_nxt[RB-9:0], c};
              if (rlen_nxt <= LENW'(REG_NAME_CHARS)) rlen_nxt = rlen_nxt + 1'b1;
            end else begin
              hit = reg_lookup(rbuf_nxt[31:0], 3'(rlen_nxt));
              if (rdig_nxt) hit = {mag_nxt <= 33'd31, mag_nxt[4:0]};
              else if (rlen_nxt > LENW'(4)) hit = '0;
              if (!hit[5]) begin
                push(q, n, mk(KIND_ERROR, '0, '0, ERR_BAD_REG, tl_nxt, tc_nxt));
                mode_nxt = M_HALT;
              end else begin
                push(q, n, mk(KIND_REGISTER, '0, 32'(hit[4:0]), ERR_NONE, tl_nxt, tc_nxt));
                mode_nxt = M_IDLE;
                go = 1'b1;
              end
            end
          end
          M_NSIGN: begin
            if (!is_digit(c)) begin
              push(q, n, mk(KIND_ERROR, '0, '0, ERR_BAD_CHAR, tl_nxt, tc_nxt));
              mode_nxt = M_HALT;
            end else if (c == 8'h30) mode_nxt = M_NZERO;
            else begin
              mag_nxt = 33'(c - 8'h30);
              mode_nxt = M_NDIGITS;
            end
          end
          M_NZERO: begin
            v = digit_in(c, BASE_OCT);
            if (c == 8'h78 || c == 8'h58) begin
              mode_nxt = M_NXPEND;
              esc_nxt = 9'(c);
              xcol_nxt = cc_r;
            end else if (v < 5'd16) begin
              base_nxt = BASE_OCT; mag_nxt = 33'(v); mode_nxt = M_NDIGITS;
            end else begin
              // The magnitude is zero here, so this number is always in range.
              push(q, n, mk(KIND_NUMBER, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_IDLE;
              go = 1'b1;
            end
          end
          M_NXPEND: begin
            v = digit_in(c, BASE_HEX);
            if (v < 5'd16) begin
              base_nxt = BASE_HEX; mag_nxt = 33'(v); mode_nxt = M_NDIGITS;
            end else begin
              // Number zero, then the x opens a symbol at its own column.
              push(q, n, mk(KIND_NUMBER, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
              tc_nxt = xcol_nxt;
              push(q, n, mk(KIND_TEXT, esc_nxt[7:0], '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_SYMBOL;
              go = 1'b1;
            end
          end
          M_NDIGITS: begin
            v = digit_in(c, base_nxt);
            if (v < 5'd16) begin
              unique case (base_nxt)
                BASE_DEC: prod = (38'(mag_nxt) << 3) + (38'(mag_nxt) << 1);
                BASE_OCT: prod = 38'(mag_nxt) << 3;
                default:  prod = 38'(mag_nxt) << 4;
              endcase
              prod = prod + 38'(v);
              mag_nxt = (prod > 38'(MAG_SAT)) ? MAG_SAT : prod[32:0];
            end else begin
              bad = neg_nxt ? (mag_nxt > 33'h080000000) : (mag_nxt > 33'h07fffffff);
              val = neg_nxt ? (32'd0 - mag_nxt[31:0]) : mag_nxt[31:0];
              if (bad) begin
                push(q, n, mk(KIND_ERROR, '0, '0, ERR_RANGE, tl_nxt, tc_nxt));
                mode_nxt = M_HALT;
              end else begin
                push(q, n, mk(KIND_NUMBER, '0, val, ERR_NONE, tl_nxt, tc_nxt));
                mode_nxt = M_IDLE;
                go = 1'b1;
              end
            end
          end
          M_STRING: begin
            if (c == 8'h22) begin
              push(q, n, mk(KIND_STRING, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_IDLE;
            end else if (c == 8'h5c) mode_nxt = M_ESCAPE;
            else push(q, n, mk(KIND_TEXT, c, '0, ERR_NONE, tl_nxt, tc_nxt));
          end
          M_ESCAPE: begin
            if (c >= 8'h30 && c <= 8'h37) begin
              esc_nxt = 9'(c - 8'h30); escd_nxt = 2'd1; mode_nxt = M_OCTAL;
            end else begin
              push(q, n, mk(KIND_TEXT, unescape(c), '0, ERR_NONE, tl_nxt, tc_nxt));
              mode_nxt = M_STRING;
            end
          end
          M_OCTAL: begin
            if (c >= 8'h30 && c <= 8'h37 && escd_nxt < 2'd3) begin
              esc_nxt = (esc_nxt << 3) + 9'(c - 8'h30);
              escd_nxt = escd_nxt + 2'd1;
              if (escd_nxt == 2'd3) begin
                push(q, n, mk(KIND_TEXT, esc_nxt[7:0], '0, ERR_NONE, tl_nxt, tc_nxt));
                escd_nxt = 2'd0;
                mode_nxt = M_STRING;
              end
            end else begin
              push(q, n, mk(KIND_TEXT, esc_nxt[7:0], '0, ERR_NONE, tl_nxt, tc_nxt));
              escd_nxt = 2'd0;
              mode_nxt = M_STRING;
              go = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    if (mode_r != M_HALT) begin
      if (c == 8'h0a) begin
        if (cl_r != {LB{1'b1}}) cl_nxt = cl_r + 1'b1;
        cc_nxt = CB'(1);
      end else if (cc_r != {CB{1'b1}}) begin
        cc_nxt = cc_r + 1'b1;
      end
    end

    if (last_char && mode_nxt != M_HALT && mode_r != M_HALT) begin
      unique case (mode_nxt)
        M_DIRECTIVE: push(q, n, mk(KIND_DIRECTIVE, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
        M_SYMBOL:    push(q, n, mk(KIND_SYMBOL, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
        M_REGISTER: begin
          hit = reg_lookup(rbuf_nxt[31:0], 3'(rlen_nxt));
          if (rdig_nxt) hit = {mag_nxt <= 33'd31, mag_nxt[4:0]};
          else if (rlen_nxt > LENW'(4)) hit = '0;
          if (!hit[5]) begin
            push(q, n, mk(KIND_ERROR, '0, '0, ERR_BAD_REG, tl_nxt, tc_nxt));
            mode_nxt = M_HALT;
          end else begin
            push(q, n, mk(KIND_REGISTER, '0, 32'(hit[4:0]), ERR_NONE, tl_nxt, tc_nxt));
          end
        end
        M_NSIGN: begin
          push(q, n, mk(KIND_ERROR, '0, '0, ERR_BAD_CHAR, tl_nxt, tc_nxt));
          mode_nxt = M_HALT;
        end
        M_NZERO, M_NDIGITS: begin
          bad = neg_nxt ? (mag_nxt > 33'h080000000) : (mag_nxt > 33'h07fffffff);
          val = neg_nxt ? (32'd0 - mag_nxt[31:0]) : mag_nxt[31:0];
          if (bad) begin
            push(q, n, mk(KIND_ERROR, '0, '0, ERR_RANGE, tl_nxt, tc_nxt));
            mode_nxt = M_HALT;
          end else begin
            push(q, n, mk(KIND_NUMBER, '0, val, ERR_NONE, tl_nxt, tc_nxt));
          end
        end
        M_NXPEND: begin
          push(q, n, mk(KIND_NUMBER, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
          tc_nxt = xcol_nxt;
          push(q, n, mk(KIND_TEXT, esc_nxt[7:0], '0, ERR_NONE, tl_nxt, tc_nxt));
          push(q, n, mk(KIND_SYMBOL, '0, '0, ERR_NONE, tl_nxt, tc_nxt));
        end
        M_STRING, M_ESCAPE, M_OCTAL: begin
          push(q, n, mk(KIND_ERROR, '0, '0, ERR_UNTERM, tl_nxt, tc_nxt));
          mode_nxt = M_HALT;
        end
        default: ;
      endcase
      if (mode_nxt != M_HALT) begin
        mode_nxt = M_IDLE;
        cl_nxt = LB'(1);
        cc_nxt = CB'(1);
      end
    end

    res_q = q;
    res_n = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      cl_r   <= LB'(1);
      cc_r   <= CB'(1);
      tl_r   <= LB'(1);
      tc_r   <= CB'(1);
      xcol_r <= '0;
      mag_r  <= '0;
      neg_r  <= 1'b0;
      base_r <= BASE_DEC;
      rbuf_r <= '0;
      rlen_r <= '0;
      rdig_r <= 1'b1;
      esc_r  <= '0;
      escd_r <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      cl_r   <= cl_nxt;
      cc_r   <= cc_nxt;
      tl_r   <= tl_nxt;
      tc_r   <= tc_nxt;
      xcol_r <= xcol_nxt;
      mag_r  <= mag_nxt;
      neg_r  <= neg_nxt;
      base_r <= base_nxt;
      rbuf_r <= rbuf_nxt;
      rlen_r <= rlen_nxt;
      rdig_r <= rdig_nxt;
      esc_r  <= esc_nxt;
      escd_r <= escd_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/assembly_source_tokenizer_unit.sv
`default_nettype none
// Streaming assembly tokenizer: one source character is taken per beat and
// every token record it causes is computed in the same cycle, then held in a
// four-entry result buffer that drains one result beat per cycle while the
// sink is ready. With a ready sink the block takes a character every cycle
// as long as each character causes at most one result; one that causes
// more holds the input until one result is left, due to the single port.
// After an error the block drops all further input until reset.
module assembly_source_tokenizer_unit
  import ast_pkg::*;
#(
  parameter int LINE_BITS      = 16,
  parameter int COLUMN_BITS    = 16,
  parameter int REG_NAME_CHARS = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  ast_in_if.sink     in_chan,
  ast_out_if.source  out_chan
);

  res_t [3:0] step_q;
  logic [2:0] step_n;
  res_t [3:0] q_r;
  logic [2:0] cnt_r;
  logic [1:0] head_r;
  logic       acc;
  logic       take;
  res_t       head;

  assign take = out_chan.valid && out_chan.ready;
  assign in_chan.ready = (cnt_r == 3'd0) || (cnt_r == 3'd1 && out_chan.ready);
  assign acc = in_chan.valid && in_chan.ready;

  ast_step #(
    .LINE_BITS     (LINE_BITS),
    .COLUMN_BITS   (COLUMN_BITS),
    .REG_NAME_CHARS(REG_NAME_CHARS)
  ) u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .char_byte(in_chan.char_byte),
    .last_char(in_chan.last_char),
    .res_q    (step_q),
    .res_n    (step_n)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 3'd0;
      head_r <= 2'd0;
    end else if (acc) begin
      cnt_r  <= step_n;
      head_r <= 2'd0;
    end else if (take) begin
      cnt_r  <= cnt_r - 3'd1;
      head_r <= head_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) q_r <= step_q;
  end

  assign head                  = q_r[head_r];
  assign out_chan.valid        = (cnt_r != 3'd0);
  assign out_chan.token_kind   = head.kind;
  assign out_chan.text_byte    = head.text;
  assign out_chan.token_value  = head.value;
  assign out_chan.error_code   = head.err;
  assign out_chan.start_line   = head.line;
  assign out_chan.start_column = head.col;
  // The final beat of a character's results is the one that empties the buffer.
  assign out_chan.last_result  = (cnt_r == 3'd1);

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(MAX_RESULTS))
    else $error("result count above buffer depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 3'd0 |-> (3'(head_r) + cnt_r) <= 3'(MAX_RESULTS))
    else $error("result read beyond the buffered beats");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    take && !acc && cnt_r > 3'd1 |=> cnt_r == $past(cnt_r) - 3'd1)
    else $error("result buffer did not drain by one beat");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.ready |-> cnt_r <= 3'd1)
    else $error("input taken while several results wait");

endmodule
`default_nettype wire

FILE: dv/assembly_source_tokenizer_unit_tb.sv
`timescale 1ns / 100ps
module assembly_source_tokenizer_unit_tb
  import ast_pkg::*;
;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef enum logic [3:0] {
    LX_IDLE, LX_COMMENT, LX_DIRECTIVE, LX_SYMBOL, LX_REGISTER, LX_NSIGN, LX_NZERO,
    LX_NXPEND, LX_NDIGITS, LX_STRING, LX_ESCAPE, LX_OCTAL, LX_HALT
  } lex_mode_e;

  typedef struct {
    res_t r;
    logic last;
  } tok_exp_t;

  typedef struct {
    logic [7:0] c;
    logic       last;
    logic       quick;
  } src_char_t;

  logic clk;
  logic rst_n;

  ast_in_if  in_if ();
  ast_out_if out_if ();

  assembly_source_tokenizer_unit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  string abi_names [32] = '{
    "zero", "at", "v0", "v1", "a0", "a1", "a2", "a3",
    "t0", "t1", "t2", "t3", "t4", "t5", "t6", "t7",
    "s0", "s1", "s2", "s3", "s4", "s5", "s6", "s7",
    "t8", "t9", "k0", "k1", "gp", "sp", "fp", "ra"
  };

  // Predictor state.
  lex_mode_e   lx_mode;
  logic [15:0] lx_line, lx_col, tk_line, tk_col;
  logic [63:0] num_mag;
  logic        num_neg;
  logic [1:0]  num_base;
  logic [63:0] reg_buf;
  int          reg_len;
  logic        reg_digits;
  logic [8:0]  esc_acc;
  int          esc_cnt;

  tok_exp_t  step_q [$];
  tok_exp_t  tok_expq [$];
  src_char_t src_q [$];

  int  n_fail;
  int  n_chars;
  int  n_tokens;
  int  cyc;
  logic in_fire, out_fire;
  logic busy;
  logic quick_now;
  int  gap_left, calm_left, stall_left, hold_left;
  bit  hold_done;

  function automatic bit ch_blank(logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0b || c == 8'h0c || c == 8'h0d;
  endfunction

  function automatic bit ch_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit ch_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic int dig_val(logic [7:0] c, logic [1:0] base);
    int v;
    v = 16;
    if (ch_digit(c)) v = c - "0";
    else if (c >= "a" && c <= "f") v = c - "a" + 10;
    else if (c >= "A" && c <= "F") v = c - "A" + 10;
    if (base == BASE_DEC && v > 9) v = 16;
    if (base == BASE_OCT && v > 7) v = 16;
    return v;
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] c);
    case (c)
      "b":     return 8'd8;
      "f":     return 8'd12;
      "n":     return 8'd10;
      "r":     return 8'd13;
      "t":     return 8'd9;
      "v":     return 8'd11;
      default: return c;
    endcase
  endfunction

  function automatic void put_tok(logic [3:0] k, logic [7:0] t, logic [31:0] v,
                                  logic [2:0] e, logic [15:0] l, logic [15:0] c);
    tok_exp_t x;
    if (step_q.size() >= MAX_RESULTS) return;
    x.r.kind = k;
    x.r.text = t;
    x.r.value = v;
    x.r.err = e;
    x.r.line = l;
    x.r.col = c;
    x.last = 1'b0;
    step_q.push_back(x);
  endfunction

  function automatic void raise_err(logic [2:0] e, logic [15:0] l, logic [15:0] c);
    put_tok(KIND_ERROR, 8'd0, 32'd0, e, l, c);
    lx_mode = LX_HALT;
  endfunction

  function automatic void close_number();
    logic [63:0] lim;
    logic [31:0] v;
    lim = num_neg ? 64'h8000_0000 : 64'h7fff_ffff;
    if (num_mag > lim) begin
      raise_err(ERR_RANGE, tk_line, tk_col);
      return;
    end
    v = num_mag[31:0];
    if (num_neg) v = -v;
    put_tok(KIND_NUMBER, 8'd0, v, ERR_NONE, tk_line, tk_col);
    lx_mode = LX_IDLE;
  endfunction

  function automatic void close_register();
    int found;
    logic [63:0] pk;
    string nm;
    found = -1;
    if (reg_digits) begin
      if (num_mag <= 31) found = int'(num_mag);
    end else if (reg_len <= 4) begin
      for (int i = 0; i < 32; i++) begin
        nm = abi_names[i];
        pk = 0;
        for (int k = 0; k < nm.len(); k++) pk = (pk << 8) | nm[k];
        if (found < 0 && nm.len() == reg_len && pk == reg_buf) found = i;
      end
    end
    if (found < 0) begin
      raise_err(ERR_BAD_REG, tk_line, tk_col);
      return;
    end
    put_tok(KIND_REGISTER, 8'd0, 32'(found), ERR_NONE, tk_line, tk_col);
    lx_mode = LX_IDLE;
  endfunction

  // A pending 0x with no hex digit gives 0 and the x opens a symbol.
  function automatic void release_x();
    close_number();
    lx_mode = LX_SYMBOL;
    tk_col = reg_buf[15:0];
    put_tok(KIND_TEXT, esc_acc[7:0], 32'd0, ERR_NONE, tk_line, tk_col);
  endfunction

  function automatic void lex_feed(logic [7:0] c, logic [15:0] l, logic [15:0] col);
    bit again;
    int v;
    do begin
      again = 0;
      case (lx_mode)
        LX_IDLE: begin
          if (ch_blank(c)) return;
          tk_line = l;
          tk_col = col;
          if (c == ".") lx_mode = LX_DIRECTIVE;
          else if (c == "$") begin
            lx_mode = LX_REGISTER;
            reg_buf = 0;
            reg_len = 0;
            reg_digits = 1;
            num_mag = 0;
          end else if (ch_alpha(c)) begin
            lx_mode = LX_SYMBOL;
            put_tok(KIND_TEXT, c, 32'd0, ERR_NONE, l, col);
          end else if (ch_digit(c) || c == "-" || c == "+") begin
            num_mag = 0;
            num_neg = 0;
            num_base = BASE_DEC;
            if (c == "-" || c == "+") begin
              num_neg = (c == "-");
              lx_mode = LX_NSIGN;
            end else if (c == "0") lx_mode = LX_NZERO;
            else begin
              num_mag = c - "0";
              lx_mode = LX_NDIGITS;
            end
          end else if (c == 8'h22) lx_mode = LX_STRING;
          else if (c == ",") put_tok(KIND_COMMA, 8'd0, 32'd0, ERR_NONE, l, col);
          else if (c == 8'h0a) put_tok(KIND_NEWLINE, 8'd0, 32'd0, ERR_NONE, l, col);
          else if (c == ";") lx_mode = LX_COMMENT;
          else raise_err(ERR_BAD_CHAR, l, col);
        end
        LX_COMMENT: begin
          if (c == 8'h0a) begin
            lx_mode = LX_IDLE;
            again = 1;
          end
        end
        LX_DIRECTIVE: begin
          if (ch_alpha(c)) put_tok(KIND_TEXT, c, 32'd0, ERR_NONE, tk_line, tk_col);
          else begin
            put_tok(KIND_DIRECTIVE, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
            lx_mode = LX_IDLE;
            again = 1;
          end
        end
        LX_SYMBOL: begin
          if (ch_alpha(c)) put_tok(KIND_TEXT, c, 32'd0, ERR_NONE, tk_line, tk_col);
          else if (c == ":") begin
            put_tok(KIND_LABEL, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
            lx_mode = LX_IDLE;
          end else begin
            put_tok(KIND_SYMBOL, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
            lx_mode = LX_IDLE;
            again = 1;
          end
        end
        LX_REGISTER: begin
          if (ch_alpha(c) || ch_digit(c)) begin
            if (!ch_digit(c)) reg_digits = 0;
            if (reg_digits) begin
              num_mag = num_mag * 10 + (c - "0");
              if (num_mag > 32) num_mag = 32;
            end
            if (reg_len < 4) reg_buf = (reg_buf << 8) | c;
            if (reg_len <= 4) reg_len++;
          end else begin
            close_register();
            if (lx_mode != LX_HALT) again = 1;
          end
        end
        LX_NSIGN: begin
          if (!ch_digit(c)) raise_err(ERR_BAD_CHAR, tk_line, tk_col);
          else if (c == "0") lx_mode = LX_NZERO;
          else begin
            num_mag = c - "0";
            lx_mode = LX_NDIGITS;
          end
        end
        LX_NZERO: begin
          if (c == "x" || c == "X") begin
            lx_mode = LX_NXPEND;
            esc_acc = {1'b0, c};
            reg_buf = col;
          end else begin
            v = dig_val(c, BASE_OCT);
            if (v < 16) begin
              num_base = BASE_OCT;
              num_mag = v;
              lx_mode = LX_NDIGITS;
            end else begin
              close_number();
              again = 1;
            end
          end
        end
        LX_NXPEND: begin
          v = dig_val(c, BASE_HEX);
          if (v < 16) begin
            num_base = BASE_HEX;
            num_mag = v;
            lx_mode = LX_NDIGITS;
          end else begin
            release_x();
            again = 1;
          end
        end
        LX_NDIGITS: begin
          v = dig_val(c, num_base);
          if (v < 16) begin
            num_mag = num_mag * (num_base == BASE_DEC ? 10 : (num_base == BASE_OCT ? 8 : 16))
                      + v;
            if (num_mag > 64'h1_0000_0000) num_mag = 64'h1_0000_0000;
          end else begin
            close_number();
            if (lx_mode != LX_HALT) again = 1;
          end
        end
        LX_STRING: begin
          if (c == 8'h22) begin
            put_tok(KIND_STRING, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
            lx_mode = LX_IDLE;
          end else if (c == 8'h5c) lx_mode = LX_ESCAPE;
          else put_tok(KIND_TEXT, c, 32'd0, ERR_NONE, tk_line, tk_col);
        end
        LX_ESCAPE: begin
          if (c >= "0" && c <= "7") begin
            esc_acc = c - "0";
            esc_cnt = 1;
            lx_mode = LX_OCTAL;
          end else begin
            put_tok(KIND_TEXT, esc_map(c), 32'd0, ERR_NONE, tk_line, tk_col);
            lx_mode = LX_STRING;
          end
        end
        LX_OCTAL: begin
          if (c >= "0" && c <= "7" && esc_cnt < 3) begin
            esc_acc = (esc_acc << 3) + (c - "0");
            esc_cnt++;
            if (esc_cnt >= 3) begin
              put_tok(KIND_TEXT, esc_acc[7:0], 32'd0, ERR_NONE, tk_line, tk_col);
              esc_cnt = 0;
              lx_mode = LX_STRING;
            end
          end else begin
            put_tok(KIND_TEXT, esc_acc[7:0], 32'd0, ERR_NONE, tk_line, tk_col);
            esc_cnt = 0;
            lx_mode = LX_STRING;
            again = 1;
          end
        end
        default: ;
      endcase
    end while (again);
  endfunction

  function automatic void lex_flush();
    case (lx_mode)
      LX_DIRECTIVE: put_tok(KIND_DIRECTIVE, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
      LX_SYMBOL:    put_tok(KIND_SYMBOL, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
      LX_REGISTER:  close_register();
      LX_NSIGN:     raise_err(ERR_BAD_CHAR, tk_line, tk_col);
      LX_NZERO, LX_NDIGITS: close_number();
      LX_NXPEND: begin
        release_x();
        put_tok(KIND_SYMBOL, 8'd0, 32'd0, ERR_NONE, tk_line, tk_col);
      end
      LX_STRING, LX_ESCAPE, LX_OCTAL: raise_err(ERR_UNTERM, tk_line, tk_col);
      default: ;
    endcase
  endfunction

  function automatic void lex_predict(logic [7:0] c, logic last);
    step_q.delete();
    if (lx_mode == LX_HALT) return;
    lex_feed(c, lx_line, lx_col);
    if (c == 8'h0a) begin
      if (lx_line != 16'hffff) lx_line++;
      lx_col = 1;
    end else if (lx_col != 16'hffff) lx_col++;
    if (last && lx_mode != LX_HALT) begin
      lex_flush();
      if (lx_mode != LX_HALT) begin
        lx_mode = LX_IDLE;
        lx_line = 1;
        lx_col = 1;
      end
    end
    if (step_q.size() > 0) step_q[step_q.size() - 1].last = 1'b1;
    foreach (step_q[i]) tok_expq.push_back(step_q[i]);
  endfunction

  // Source text generation.
  task automatic put_ch(logic [7:0] c, logic last = 1'b0, logic quick = 1'b0);
    src_char_t s;
    s.c = c;
    s.last = last;
    s.quick = quick;
    src_q.push_back(s);
  endtask

  task automatic put_str(string s, logic last_end = 1'b0);
    for (int i = 0; i < s.len(); i++) put_ch(s[i], last_end && (i == s.len() - 1));
  endtask

  task automatic put_sep();
    logic [7:0] seps [7] = '{8'h20, 8'h09, 8'h2c, 8'h0a, 8'h0d, 8'h0b, 8'h0c};
    put_ch(seps[$urandom_range(0, 6)], $urandom_range(0, 14) == 0);
  endtask

  task automatic put_number();
    int form, sgn;
    longint m;
    string s;
    form = $urandom_range(0, 5);
    sgn = $urandom_range(0, 2);
    m = $urandom_range(0, 9);
    if ($urandom_range(0, 1)) m = $urandom() & 32'h7fff_ffff;
    if ($urandom_range(0, 7) == 0) m = (sgn == 1) ? 64'h8000_0000 : 64'h7fff_ffff;
    case (form)
      0, 1: s = $sformatf("%0d", m);
      2: begin
        s = $sformatf("0x%0h", m);
        if ($urandom_range(0, 1)) s = s.toupper();
      end
      3: s = $sformatf("0%0o", m);
      4: begin
        s = $urandom_range(0, 1) ? "0x" : "0X";
        sgn = 0;
      end
      default: begin
        s = "08";
        sgn = 0;
      end
    endcase
    if (sgn == 1) s = {"-", s};
    else if (sgn == 2) s = {"+", s};
    put_str(s, $urandom_range(0, 9) == 0);
  endtask

  task automatic put_letters(int lo, int hi);
    int n;
    n = $urandom_range(lo, hi);
    for (int i = 0; i < n; i++)
      put_ch($urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z")));
  endtask

  task automatic put_string_tok();
    int n, k;
    logic [7:0] b;
    string escs;
    escs = "bfnrtvq\"\\";
    put_ch(8'h22);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 3);
      if (k == 0) begin
        put_ch(8'h5c);
        put_ch(escs[$urandom_range(0, escs.len() - 1)]);
      end else if (k == 1) begin
        put_ch(8'h5c);
        k = $urandom_range(1, 3);
        for (int j = 0; j < k; j++) put_ch(8'($urandom_range("0", "7")));
      end else begin
        do b = $urandom_range(0, 255); while (b == 8'h22 || b == 8'h5c);
        put_ch(b);
      end
    end
    put_ch(8'h22, $urandom_range(0, 9) == 0);
  endtask

  task automatic put_token();
    int k;
    logic [7:0] b;
    k = $urandom_range(0, 9);
    case (k)
      0: begin
        put_ch(".");
        put_letters(0, 5);
      end
      1, 2: begin
        put_letters(1, 6);
        if ($urandom_range(0, 2) == 0) put_ch(":");
      end
      3, 4: put_number();
      5: put_string_tok();
      6, 7: begin
        put_ch("$");
        case ($urandom_range(0, 2))
          0: put_str($sformatf("%0d", $urandom_range(0, 31)));
          1: put_str(abi_names[$urandom_range(0, 31)]);
          default: ;
        endcase
      end
      8: begin
        put_ch(";");
        repeat ($urandom_range(0, 8)) begin
          do b = $urandom_range(0, 255); while (b == 8'h0a);
          put_ch(b);
        end
        put_ch(8'h0a);
      end
      default: put_ch($urandom_range(0, 1) ? 8'h2c : 8'h0a);
    endcase
    put_sep();
  endtask

  // The run ends on one error, since the block halts until reset.
  task automatic put_error_tail();
    logic [7:0] bad [4] = '{"#", 8'h00, 8'hc8, "@"};
    case ($urandom_range(0, 4))
      0: put_ch(bad[$urandom_range(0, 3)]);
      1: put_str($urandom_range(0, 1) ? "-x" : "+,");
      2: begin
        case ($urandom_range(0, 2))
          0: put_str("$zeroo ");
          1: put_str("$40 ");
          default: put_str("$qq ");
        endcase
      end
      3: put_str("\"ab", 1'b1);
      default: begin
        case ($urandom_range(0, 2))
          0: put_str("4294967296 ");
          1: put_str("-2147483649 ");
          default: put_str("0x100000000 ");
        endcase
      end
    endcase
    put_str("abc");
  endtask

  function automatic int draw_wait();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = 20;
    return $urandom_range(0, 7);
  endfunction

  // Acceptance, prediction and checking at the rising edge.
  always @(posedge clk) begin
    tok_exp_t x;
    in_fire <= rst_n && in_if.valid && in_if.ready;
    out_fire <= rst_n && out_if.valid && out_if.ready;
    if (rst_n && in_if.valid && in_if.ready) begin
      n_chars++;
      lex_predict(in_if.char_byte, in_if.last_char);
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      if (tok_expq.size() == 0) begin
        $display("%0t: unexpected token beat kind %0d line %0d col %0d", $time,
                 out_if.token_kind, out_if.start_line, out_if.start_column);
        n_fail++;
      end else begin
        x = tok_expq.pop_front();
        n_tokens++;
        if (out_if.token_kind !== x.r.kind || out_if.text_byte !== x.r.text ||
            out_if.token_value !== x.r.value || out_if.error_code !== x.r.err ||
            out_if.start_line !== x.r.line || out_if.start_column !== x.r.col ||
            out_if.last_result !== x.last) begin
          $display("%0t: token mismatch expected k%0d t%02h v%08h e%0d l%0d c%0d last%0b",
                   $time, x.r.kind, x.r.text, x.r.value, x.r.err, x.r.line, x.r.col, x.last);
          $display("%0t:                   actual k%0d t%02h v%08h e%0d l%0d c%0d last%0b",
                   $time, out_if.token_kind, out_if.text_byte, out_if.token_value,
                   out_if.error_code, out_if.start_line, out_if.start_column,
                   out_if.last_result);
          n_fail++;
        end
      end
    end
  end

  // Character driver.
  always @(negedge clk) begin
    src_char_t s;
    if (rst_n) begin
      if (busy && !in_fire) begin
      end else if (gap_left > 0) begin
        gap_left--;
        busy = 0;
        in_if.valid <= 1'b0;
      end else if (src_q.size() > 0) begin
        s = src_q.pop_front();
        in_if.char_byte <= s.c;
        in_if.last_char <= s.last;
        in_if.valid <= 1'b1;
        busy = 1;
        quick_now = s.quick;
        gap_left = s.quick ? 0 : draw_wait();
      end else begin
        busy = 0;
        in_if.valid <= 1'b0;
      end
    end
  end

  // Token receiver, with one long hold-off early in the run.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (!hold_done && n_tokens >= 25) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_if.ready <= 1'b0;
      end else begin
        if (out_fire) stall_left = quick_now ? 0 : draw_wait();
        else if (stall_left > 0) stall_left--;
        out_if.ready <= (stall_left == 0);
      end
    end
  end

  initial begin
    while (cyc < CYCLE_LIMIT) begin
      @(posedge clk);
      cyc++;
    end
    $display("FAIL assembly_source_tokenizer_unit");
    $finish;
  end

  initial begin
    int n_random;
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.char_byte = 8'h00;
    in_if.last_char = 1'b0;
    out_if.ready = 1'b0;
    n_fail = 0;
    n_chars = 0;
    n_tokens = 0;
    cyc = 0;
    in_fire = 0;
    out_fire = 0;
    busy = 0;
    quick_now = 0;
    gap_left = 0;
    calm_left = 0;
    stall_left = 0;
    hold_left = 0;
    hold_done = 0;
    lx_mode = LX_IDLE;
    lx_line = 1;
    lx_col = 1;
    tk_line = 1;
    tk_col = 1;
    num_mag = 0;
    num_neg = 0;
    num_base = BASE_DEC;
    reg_buf = 0;
    reg_len = 0;
    reg_digits = 1;
    esc_acc = 0;
    esc_cnt = 0;

    // Directed text: every token kind but error, the number edges, 0x and octal stop
    // (a pending 0x ended by a comma gives four beats), escapes, a comment,
    // and a flush of a pending 0x at the final character.
    put_str(".text\nmain: $sp,$31,$,-2147483648 0x7FFFFFFF 08 0x,");
    put_str("\"\\n\\101\\\"\\7\";c\n");
    put_str("0x", 1'b1);

    n_random = src_q.size();
    while (src_q.size() - n_random < 180) put_token();
    put_error_tail();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (src_q.size() > 0 || busy) @(posedge clk);
    while (tok_expq.size() > 0) @(posedge clk);
    repeat (32) @(posedge clk);

    $display("Lexed %0d source characters into %0d checked token beats,", n_chars, n_tokens);
    $display("with random idling on both sides, a long output hold-off and one final error.");
    if (n_fail == 0 && tok_expq.size() == 0) begin
      $display("PASS assembly_source_tokenizer_unit");
    end else begin
      $display("FAIL assembly_source_tokenizer_unit");
    end
    $finish;
  end

endmodule
